@@ rtl/foc_pkg.sv @@
// Shared types and constants for the PMSM field-oriented control step.
// Holds the sequencer state type, register indexes and the sine table builder.
package foc_pkg;

  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);

  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [15:0] sine_rom_t [SINE_ENTRIES];

  typedef enum logic [2:0] {
    REG_SPEED_KP        = 3'd0,
    REG_SPEED_KI        = 3'd1,
    REG_SPEED_LIMIT     = 3'd2,
    REG_CURRENT_KP      = 3'd3,
    REG_CURRENT_KI      = 3'd4,
    REG_D_VOLTAGE_LIMIT = 3'd5,
    REG_Q_VOLTAGE_LIMIT = 3'd6,
    REG_SPEED_DIVIDE    = 3'd7
  } reg_index_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_SIN, ST_RD_COS, ST_COS,
    ST_SPD_KI, ST_SPD_KP, ST_SPD_OUT,
    ST_PARK1, ST_PARK2, ST_PARK3, ST_PARK4, ST_PARK5,
    ST_D_KI, ST_D_KP, ST_D_OUT, ST_Q_KP, ST_Q_OUT,
    ST_INV1, ST_INV2, ST_INV3, ST_INV4, ST_INV5,
    ST_DONE
  } state_t;

  // Entry k is 32767*sin(2*pi*k/SINE_ENTRIES) from an odd Taylor series in Q30.
  function automatic sine_rom_t build_sine();
    sine_rom_t tbl;
    longint unsigned p, quad, r, x, x2, t, s, v;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      p = (longint'(k) << 32) / SINE_ENTRIES;
      quad = (p >> 30) & 64'd3;
      r = p & (ONE_Q30 - 64'd1);
      if (quad == 64'd1 || quad == 64'd3) begin
        r = ONE_Q30 - r;
      end
      x = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t = ONE_Q30;
      t = ONE_Q30 - ((x2 * t) >> 30) / 110;
      t = ONE_Q30 - ((x2 * t) >> 30) / 72;
      t = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s = (x * t) >> 30;
      v = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tbl[k] = (quad >= 64'd2) ? 16'(64'd0 - v) : 16'(v);
    end
    return tbl;
  endfunction

endpackage

@@ rtl/pmsm_field_oriented_control_step.sv @@
// PMSM field-oriented control step: speed PI, Park, current PIs, inverse Park.
// Uses foc_pkg for the sequencer states, register indexes and sine table.
//
// One transfer on the s_ group carries one control period; one transfer on the
// m_ group returns its voltages, Park currents and q-current command. The
// configuration port writes register cfg_index with cfg_data when cfg_write is
// high; write only while no period is in flight.
// The work is sequenced through one shared 33x21 multiplier, one product per
// cycle, and through two add/round/clamp units, one for the PI steps and one
// for the rotations; the sine ROM is read twice through its single registered
// port. s_tready is high only while the sequencer is idle, so a new period is
// not accepted until the previous one has left its end state.
// A finished result sits in the output register until taken; the next period
// is accepted meanwhile and waits at its end if the result was not yet taken.
// Reset clears the integrators, the q-current command, the period counter and
// the output valid, and loads the register defaults.
module pmsm_field_oriented_control_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // speed_target[19:0], speed_feedback[39:20], i_alpha[55:40], i_beta[71:56],
  // rotor_angle[87:72]
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // v_alpha[15:0], v_beta[31:16], i_d[47:32], i_q[63:48], q_current_cmd[79:64]
  output logic [79:0] m_tdata,
  // speed_loop_ran[0]
  output logic        m_tuser,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam foc_pkg::sine_rom_t SINE_ROM = foc_pkg::build_sine();

  foc_pkg::state_t state, state_next;

  logic [31:0] speed_kp, speed_ki, current_kp, current_ki;
  logic [14:0] speed_limit, d_voltage_limit, q_voltage_limit;
  logic [7:0]  speed_divide, divide_count;

  logic signed [31:0] speed_integral, d_integral, q_integral;
  logic signed [15:0] q_current_target;

  logic signed [19:0] speed_target, speed_feedback;
  logic signed [15:0] i_alpha, i_beta, sn, cs, rom_q;
  logic [15:0]        rotor_angle, cos_angle;
  logic               ran;
  logic signed [15:0] i_d, i_q, v_d, v_q, v_alpha, v_beta;

  logic signed [32:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [53:0] prod;
  logic signed [32:0] sum;
  logic [foc_pkg::SINE_IDX_W-1:0] rom_addr;

  logic signed [20:0] speed_err;
  logic signed [16:0] q_err;
  logic signed [31:0] pi_base, pi_res;
  logic [14:0]        pi_lim;
  logic signed [15:0] pi_volt;
  logic               rot_sub;
  logic signed [15:0] rot_res;

  // Clamp(base + round(prod / 2^8)) to +-limit in Q16.16.
  function automatic logic signed [31:0] pi_step(input logic signed [31:0] base,
                                                 input logic signed [53:0] p,
                                                 input logic [14:0] lim);
    logic signed [54:0] rp;
    logic signed [55:0] tot;
    logic signed [55:0] l;
    rp = (55'(p) + (p[53] ? 55'sd127 : 55'sd128)) >>> 8;
    tot = 56'(base) + 56'(rp);
    l = 56'({lim, 16'd0});
    if (tot > l) begin
      return 32'(l);
    end else if (tot < -l) begin
      return 32'(-l);
    end
    return 32'(tot);
  endfunction

  // Negated round(x / 2^16); |x| never exceeds 32767 * 2^16.
  function automatic logic signed [15:0] neg_rnd16(input logic signed [31:0] x);
    logic signed [32:0] r;
    r = (33'(x) + (x[31] ? 33'sd32767 : 33'sd32768)) >>> 16;
    return 16'(-r);
  endfunction

  // Saturate round(x / 2^15) to 16 bits.
  function automatic logic signed [15:0] rnd15_sat(input logic signed [33:0] x);
    logic signed [33:0] r;
    r = (x + (x[33] ? 34'sd16383 : 34'sd16384)) >>> 15;
    if (r > 34'sd32767) begin
      return 16'sh7fff;
    end else if (r < -34'sd32768) begin
      return 16'sh8000;
    end
    return 16'(r);
  endfunction

  assign cos_angle = rotor_angle + 16'd16384;
  assign speed_err = 21'(speed_feedback) - 21'(speed_target);
  assign q_err = 17'(i_q) - 17'(q_current_target);
  assign s_tready = (state == foc_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    mul_a = '0;
    mul_b = '0;
    rom_addr = rotor_angle[15 -: foc_pkg::SINE_IDX_W];
    pi_base = q_integral;
    pi_lim = q_voltage_limit;
    rot_sub = 1'b0;
    unique case (state)
      foc_pkg::ST_IDLE:    if (s_tvalid) state_next = foc_pkg::ST_RD_SIN;
      foc_pkg::ST_RD_SIN:  state_next = foc_pkg::ST_RD_COS;
      foc_pkg::ST_RD_COS: begin
        rom_addr = cos_angle[15 -: foc_pkg::SINE_IDX_W];
        state_next = foc_pkg::ST_COS;
      end
      foc_pkg::ST_COS:     state_next = ran ? foc_pkg::ST_SPD_KI : foc_pkg::ST_PARK1;
      foc_pkg::ST_SPD_KI: begin
        mul_a = 33'({1'b0, speed_ki});
        mul_b = speed_err;
        state_next = foc_pkg::ST_SPD_KP;
      end
      foc_pkg::ST_SPD_KP: begin
        mul_a = 33'({1'b0, speed_kp});
        mul_b = speed_err;
        pi_base = speed_integral;
        pi_lim = speed_limit;
        state_next = foc_pkg::ST_SPD_OUT;
      end
      foc_pkg::ST_SPD_OUT: begin
        pi_base = speed_integral;
        pi_lim = speed_limit;
        state_next = foc_pkg::ST_PARK1;
      end
      foc_pkg::ST_PARK1: begin
        mul_a = 33'(i_alpha);
        mul_b = 21'(cs);
        state_next = foc_pkg::ST_PARK2;
      end
      foc_pkg::ST_PARK2: begin
        mul_a = 33'(i_beta);
        mul_b = 21'(sn);
        state_next = foc_pkg::ST_PARK3;
      end
      foc_pkg::ST_PARK3: begin
        mul_a = 33'(i_beta);
        mul_b = 21'(cs);
        state_next = foc_pkg::ST_PARK4;
      end
      foc_pkg::ST_PARK4: begin
        mul_a = 33'(i_alpha);
        mul_b = 21'(sn);
        state_next = foc_pkg::ST_PARK5;
      end
      foc_pkg::ST_PARK5: begin
        rot_sub = 1'b1;
        state_next = foc_pkg::ST_D_KI;
      end
      foc_pkg::ST_D_KI: begin
        mul_a = 33'({1'b0, current_ki});
        mul_b = 21'(i_d);
        state_next = foc_pkg::ST_D_KP;
      end
      foc_pkg::ST_D_KP: begin
        mul_a = 33'({1'b0, current_kp});
        mul_b = 21'(i_d);
        pi_base = d_integral;
        pi_lim = d_voltage_limit;
        state_next = foc_pkg::ST_D_OUT;
      end
      foc_pkg::ST_D_OUT: begin
        mul_a = 33'({1'b0, current_ki});
        mul_b = 21'(q_err);
        pi_base = d_integral;
        pi_lim = d_voltage_limit;
        state_next = foc_pkg::ST_Q_KP;
      end
      foc_pkg::ST_Q_KP: begin
        mul_a = 33'({1'b0, current_kp});
        mul_b = 21'(q_err);
        state_next = foc_pkg::ST_Q_OUT;
      end
      foc_pkg::ST_Q_OUT:   state_next = foc_pkg::ST_INV1;
      foc_pkg::ST_INV1: begin
        mul_a = 33'(v_d);
        mul_b = 21'(cs);
        state_next = foc_pkg::ST_INV2;
      end
      foc_pkg::ST_INV2: begin
        mul_a = 33'(v_q);
        mul_b = 21'(sn);
        state_next = foc_pkg::ST_INV3;
      end
      foc_pkg::ST_INV3: begin
        mul_a = 33'(v_d);
        mul_b = 21'(sn);
        rot_sub = 1'b1;
        state_next = foc_pkg::ST_INV4;
      end
      foc_pkg::ST_INV4: begin
        mul_a = 33'(v_q);
        mul_b = 21'(cs);
        state_next = foc_pkg::ST_INV5;
      end
      foc_pkg::ST_INV5:    state_next = foc_pkg::ST_DONE;
      foc_pkg::ST_DONE:    if (!m_tvalid || m_tready) state_next = foc_pkg::ST_IDLE;
      default:             state_next = foc_pkg::ST_IDLE;
    endcase
  end

  assign pi_res = pi_step(pi_base, prod, pi_lim);
  assign pi_volt = neg_rnd16(pi_res);
  assign rot_res = rot_sub ? rnd15_sat(34'(sum) - 34'($signed(prod[32:0])))
                           : rnd15_sat(34'(sum) + 34'($signed(prod[32:0])));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= foc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_kp <= 32'd8388608;
      speed_ki <= 32'd16005;
      speed_limit <= 15'd256;
      current_kp <= 32'd251658240;
      current_ki <= 32'd314573;
      d_voltage_limit <= 15'd11200;
      q_voltage_limit <= 15'd20800;
      speed_divide <= 8'd19;
    end else if (cfg_write) begin
      unique case (foc_pkg::reg_index_t'(cfg_index))
        foc_pkg::REG_SPEED_KP:        speed_kp <= cfg_data;
        foc_pkg::REG_SPEED_KI:        speed_ki <= cfg_data;
        foc_pkg::REG_SPEED_LIMIT:     speed_limit <= cfg_data[14:0];
        foc_pkg::REG_CURRENT_KP:      current_kp <= cfg_data;
        foc_pkg::REG_CURRENT_KI:      current_ki <= cfg_data;
        foc_pkg::REG_D_VOLTAGE_LIMIT: d_voltage_limit <= cfg_data[14:0];
        foc_pkg::REG_Q_VOLTAGE_LIMIT: q_voltage_limit <= cfg_data[14:0];
        foc_pkg::REG_SPEED_DIVIDE:    speed_divide <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    rom_q <= SINE_ROM[rom_addr];
    if (state == foc_pkg::ST_IDLE && s_tvalid) begin
      speed_target <= s_tdata[19:0];
      speed_feedback <= s_tdata[39:20];
      i_alpha <= s_tdata[55:40];
      i_beta <= s_tdata[71:56];
      rotor_angle <= s_tdata[87:72];
    end
    unique case (state)
      foc_pkg::ST_RD_COS: sn <= rom_q;
      foc_pkg::ST_COS:    cs <= rom_q;
      foc_pkg::ST_PARK2:  sum <= prod[32:0];
      foc_pkg::ST_PARK3:  i_d <= rot_res;
      foc_pkg::ST_PARK4:  sum <= prod[32:0];
      foc_pkg::ST_PARK5:  i_q <= rot_res;
      foc_pkg::ST_D_OUT:  v_d <= pi_volt;
      foc_pkg::ST_Q_OUT:  v_q <= pi_volt;
      foc_pkg::ST_INV2:   sum <= prod[32:0];
      foc_pkg::ST_INV3:   v_alpha <= rot_res;
      foc_pkg::ST_INV4:   sum <= prod[32:0];
      foc_pkg::ST_INV5:   v_beta <= rot_res;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_integral <= '0;
      d_integral <= '0;
      q_integral <= '0;
      q_current_target <= '0;
      divide_count <= '0;
      ran <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == foc_pkg::ST_IDLE && s_tvalid) begin
        ran <= (divide_count == speed_divide);
        divide_count <= (divide_count == speed_divide) ? 8'd0 : divide_count + 8'd1;
      end
      unique case (state)
        foc_pkg::ST_SPD_KP:  speed_integral <= pi_res;
        foc_pkg::ST_SPD_OUT: q_current_target <= pi_volt;
        foc_pkg::ST_D_KP:    d_integral <= pi_res;
        foc_pkg::ST_Q_KP:    q_integral <= pi_res;
        default: ;
      endcase
      if (state == foc_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == foc_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {q_current_target, i_q, i_d, v_beta, v_alpha};
      m_tuser <= ran;
    end
  end

endmodule
